/* rtl/met_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the encoder angle tracker
// Word layouts between the front end, the queue, the unwrap stage and the
// angle pipeline, and the fixed-point constants of the angle maths.
// ----------------------------------------------------------------------------
package met_pkg;

  // Fixed geometry: 13-bit encoder, 15.4:1 gear held as tenths
  localparam int ENCODER_COUNTS = 8192;
  localparam int GEAR_TENTHS    = 154;

  // Q3.13 angle constants
  localparam int Q_TWO_PI = 51472;
  localparam int Q_PI     = 25736;

  // One gear period in tenths of a count
  localparam int PERIOD = ENCODER_COUNTS * GEAR_TENTHS;
  // Turns contribute (10 * turns * 8192) mod PERIOD = 16384 * ((5 * turns) mod 77)
  localparam int RES_MOD   = GEAR_TENTHS / 2;
  localparam int TURN_STEP = (10 * ENCODER_COUNTS / 16384) % RES_MOD;
  localparam int RES_SHIFT = 14;

  // t * 51472 / PERIOD == ((t * 3217) >> 10) / 77
  localparam int ANGLE_MUL   = Q_TWO_PI / 16;
  localparam int ANGLE_SHIFT = 10;

  // Exact divide by 77 for operands below 2^22: ceil(2^32 / 77), take bits 47:32
  localparam logic [25:0] RECIP77 = 26'(((64'd1 << 32) + 64'd76) / 64'd77);

  // Configuration
  localparam int          CFG_W       = 15;
  localparam logic [12:0] JUMP_RESET  = 13'd6666;
  localparam logic [14:0] FOLD_RESET  = 15'd16384;

  typedef enum logic {
    CFG_JUMP_THRESHOLD = 1'b0,
    CFG_FOLD_LIMIT     = 1'b1
  } cfg_idx_e;

  // Queue depth between front end and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // How a motor's angle is folded after wrapping
  typedef enum logic [1:0] {
    FOLD_NONE,
    FOLD_POS,
    FOLD_NEG
  } fold_e;

  // Classified frame, front end to back end
  typedef struct packed {
    logic [2:0]         motor;
    fold_e              fold;
    logic               capture;
    logic [12:0]        enc;
    logic signed [15:0] speed;
    logic [15:0]        current;
    logic [7:0]         temp;
  } met_item_t;

  // Unwrapped frame, unwrap stage to angle pipeline
  typedef struct packed {
    logic [2:0]         motor;
    fold_e              fold;
    logic signed [15:0] turns;
    logic [6:0]         res;
    logic signed [13:0] diff;
    logic signed [15:0] speed;
    logic [15:0]        current;
    logic [7:0]         temp;
  } met_unw_t;

  // Finished result word
  typedef struct packed {
    logic [2:0]         motor;
    logic signed [16:0] angle;
    logic signed [15:0] turns;
    logic signed [12:0] speed;
    logic [15:0]        current;
    logic [7:0]         temp;
  } met_result_t;

  // Per-motor mounting trim in Q3.13
  function automatic logic signed [16:0] trim_of(input logic [2:0] motor);
    logic signed [16:0] tr;
    case (motor)
      3'd0:    tr = -17'sd7537;
      3'd1:    tr = 17'sd22118;
      3'd2:    tr = -17'sd22036;
      3'd3:    tr = 17'sd8192;
      3'd4:    tr = 17'sd6881;
      3'd5:    tr = -17'sd22938;
      3'd6:    tr = 17'sd22938;
      3'd7:    tr = -17'sd7619;
      default: tr = '0;
    endcase
    return tr;
  endfunction

  // Floor divide by 77 through the reciprocal
  function automatic logic [15:0] div77(input logic [21:0] x);
    logic [47:0] p;
    p = 48'(x) * 48'(RECIP77);
    return p[47:32];
  endfunction

endpackage

/* rtl/met_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_front: frame intake and classification
// Unpacks the incoming word, reduces the motor index to the motor range and
// tags the fold rule of the motor before the frame enters the queue.
// ----------------------------------------------------------------------------
module met_front
  import met_pkg::*;
#(
  parameter int MOTORS = 8
) (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // motor_index, encoder_count, speed_raw,
                                      // current_raw, temperature_raw
  input  logic        s_axis_tuser,   // capture_offset
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output met_item_t   push_item_o
);

  // Reduce the index modulo the motor count
  function automatic logic [2:0] wrap_motor(input logic [2:0] m);
    logic [4:0] v;
    v = {2'b00, m};
    for (int k = 0; k < 8; k++) begin
      if (v >= 5'(MOTORS)) begin
        v = v - 5'(MOTORS);
      end
    end
    return v[2:0];
  endfunction

  logic [2:0] motor;

  assign motor = wrap_motor(s_axis_tdata[2:0]);

  // Classify and unpack
  always_comb begin
    push_item_o.motor   = motor;
    push_item_o.capture = s_axis_tuser;
    push_item_o.enc     = s_axis_tdata[15:3];
    push_item_o.speed   = $signed(s_axis_tdata[31:16]);
    push_item_o.current = s_axis_tdata[47:32];
    push_item_o.temp    = s_axis_tdata[55:48];
    case (motor)
      3'd1, 3'd6: push_item_o.fold = FOLD_POS;
      3'd2, 3'd5: push_item_o.fold = FOLD_NEG;
      default:    push_item_o.fold = FOLD_NONE;
    endcase
  end

  assign push_valid_o  = s_axis_tvalid;
  assign s_axis_tready = push_ready_i;

endmodule

/* rtl/met_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_queue: short word queue between front end and back end
// Four-entry FIFO; each side stalls without holding up the other.
// ----------------------------------------------------------------------------
module met_queue
  import met_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  met_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output met_item_t pop_item_o
);

  met_item_t         buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = buf_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/met_unwrap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_unwrap: per-motor multi-turn unwrap
// Holds offset, last reading, turn count and turn residue mod 77 per motor,
// updates them for one frame a cycle unless stalled; registers the result.
// ----------------------------------------------------------------------------
module met_unwrap
  import met_pkg::*;
#(
  parameter int MOTORS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [12:0] jump_threshold_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  met_item_t   in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output met_unw_t    out_unw_o
);

  localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  logic [12:0]        zoff_q  [MOTORS];
  logic [12:0]        prev_q  [MOTORS];
  logic signed [15:0] turns_q [MOTORS];
  logic [6:0]         res_q   [MOTORS];

  logic               vld_q;
  met_unw_t           unw_q, unw_d;

  logic [MIDX_W-1:0]  mi;
  logic               take;
  logic [12:0]        zoff_n;
  logic signed [15:0] turns_b, turns_n;
  logic [6:0]         res_b, res_n;
  logic signed [13:0] delta, thr;
  logic               dec, inc;

  assign mi         = MIDX_W'(in_item_i.motor);
  assign in_ready_o = !vld_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // Capture, jump test and saturating turn step
  always_comb begin
    zoff_n  = in_item_i.capture ? in_item_i.enc : zoff_q[mi];
    turns_b = in_item_i.capture ? 16'sd0 : turns_q[mi];
    res_b   = in_item_i.capture ? 7'd0 : res_q[mi];
    delta   = $signed({1'b0, in_item_i.enc}) - $signed({1'b0, prev_q[mi]});
    thr     = $signed({1'b0, jump_threshold_i});
    dec     = (delta > thr) && (turns_b != -16'sd32768);
    inc     = (delta < -thr) && !(delta > thr) && (turns_b != 16'sd32767);
    turns_n = turns_b;
    res_n   = res_b;
    if (dec) begin
      turns_n = turns_b - 16'sd1;
      res_n   = (res_b < 7'(TURN_STEP)) ? res_b + 7'(RES_MOD - TURN_STEP)
                                         : res_b - 7'(TURN_STEP);
    end else if (inc) begin
      turns_n = turns_b + 16'sd1;
      res_n   = (res_b + 7'(TURN_STEP) >= 7'(RES_MOD))
                ? res_b + 7'(TURN_STEP) - 7'(RES_MOD)
                : res_b + 7'(TURN_STEP);
    end

    unw_d.motor   = in_item_i.motor;
    unw_d.fold    = in_item_i.fold;
    unw_d.turns   = turns_n;
    unw_d.res     = res_n;
    unw_d.diff    = $signed({1'b0, in_item_i.enc}) - $signed({1'b0, zoff_n});
    unw_d.speed   = in_item_i.speed;
    unw_d.current = in_item_i.current;
    unw_d.temp    = in_item_i.temp;
  end

  // Per-motor state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < MOTORS; m++) begin
        zoff_q[m]  <= '0;
        prev_q[m]  <= '0;
        turns_q[m] <= '0;
        res_q[m]   <= '0;
      end
    end else if (take) begin
      zoff_q[mi]  <= zoff_n;
      prev_q[mi]  <= in_item_i.enc;
      turns_q[mi] <= turns_n;
      res_q[mi]   <= res_n;
    end
  end

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      unw_q <= unw_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_unw_o   = unw_q;

endmodule

/* rtl/met_angle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_angle: angle and speed pipeline
// Reduces the unwrapped count over one gear period, scales it to Q3.13,
// adds the motor trim, wraps and folds; divides speed by the gear ratio.
// ----------------------------------------------------------------------------
module met_angle
  import met_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [14:0] fold_limit_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  met_unw_t    in_unw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output met_result_t out_res_o
);

  typedef struct packed {
    logic [2:0]         motor;
    fold_e              fold;
    logic signed [15:0] turns;
    logic [15:0]        current;
    logic [7:0]         temp;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [20:0] t;
    logic [17:0] smag;
    logic        sneg;
  } stg_a_t;

  typedef struct packed {
    side_t       side;
    logic [21:0] y;
    logic [11:0] sq;
    logic        sneg;
  } stg_b_t;

  typedef struct packed {
    side_t              side;
    logic [15:0]        ang0;
    logic signed [12:0] spd;
  } stg_c_t;

  logic        a_vld_q, b_vld_q, c_vld_q, o_vld_q;
  logic        a_rdy, b_rdy, c_rdy, o_rdy;
  stg_a_t      a_q, a_d;
  stg_b_t      b_q, b_d;
  stg_c_t      c_q, c_d;
  met_result_t o_q, o_d;

  logic signed [21:0] sum;
  logic signed [21:0] diff_x;
  logic [15:0]        mag16;
  logic [32:0]        aprod;
  logic signed [18:0] w, w2, ang, flim;

  // Stall chain, last stage first
  assign o_rdy      = !o_vld_q || out_ready_i;
  assign c_rdy      = !c_vld_q || o_rdy;
  assign b_rdy      = !b_vld_q || c_rdy;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  // Stage A: gear-period reduction and speed magnitude
  always_comb begin
    diff_x = {{8{in_unw_i.diff[13]}}, in_unw_i.diff};
    sum    = $signed({1'b0, in_unw_i.res, {RES_SHIFT{1'b0}}})
             + (diff_x <<< 3) + (diff_x <<< 1);
    if (sum < 22'sd0) begin
      a_d.t = 21'(sum + 22'(PERIOD));
    end else if (sum >= 22'(PERIOD)) begin
      a_d.t = 21'(sum - 22'(PERIOD));
    end else begin
      a_d.t = 21'(sum);
    end
    a_d.sneg = in_unw_i.speed[15];
    mag16    = a_d.sneg ? 16'(-in_unw_i.speed) : 16'(in_unw_i.speed);
    a_d.smag = {mag16, 2'b00} + 18'(mag16);
    a_d.side.motor   = in_unw_i.motor;
    a_d.side.fold    = in_unw_i.fold;
    a_d.side.turns   = in_unw_i.turns;
    a_d.side.current = in_unw_i.current;
    a_d.side.temp    = in_unw_i.temp;
  end

  // Stage B: scale to radians, divide speed
  always_comb begin
    aprod     = 33'(a_q.t) * 33'(ANGLE_MUL);
    b_d.y     = 22'(aprod >> ANGLE_SHIFT);
    b_d.sq    = 12'(div77(22'(a_q.smag)));
    b_d.sneg  = a_q.sneg;
    b_d.side  = a_q.side;
  end

  // Stage C: finish the angle divide, sign the speed
  always_comb begin
    c_d.ang0 = div77(b_q.y);
    c_d.spd  = b_q.sneg ? -$signed({1'b0, b_q.sq}) : $signed({1'b0, b_q.sq});
    c_d.side = b_q.side;
  end

  // Output stage: trim, wrap into [-pi, pi), fold
  always_comb begin
    w    = $signed({3'b000, c_q.ang0}) + 19'(trim_of(c_q.side.motor)) + 19'sd25736;
    w2   = (w >= 19'(Q_TWO_PI)) ? w - 19'(Q_TWO_PI) : w;
    ang  = w2 - 19'(Q_PI);
    flim = $signed({4'b0000, fold_limit_i});
    case (c_q.side.fold)
      FOLD_POS: begin
        if (ang > flim) begin
          ang = ang - 19'(Q_TWO_PI);
        end
      end
      FOLD_NEG: begin
        if (ang < -flim) begin
          ang = ang + 19'(Q_TWO_PI);
        end
      end
      default: begin
      end
    endcase
    o_d.motor   = c_q.side.motor;
    o_d.angle   = ang[16:0];
    o_d.turns   = c_q.side.turns;
    o_d.speed   = c_q.spd;
    o_d.current = c_q.side.current;
    o_d.temp    = c_q.side.temp;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
      if (o_rdy) o_vld_q <= c_vld_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) a_q <= a_d;
    if (b_rdy && a_vld_q)    b_q <= b_d;
    if (c_rdy && b_vld_q)    c_q <= c_d;
    if (o_rdy && c_vld_q)    o_q <= o_d;
  end

  assign out_valid_o = o_vld_q;
  assign out_res_o   = o_q;

endmodule

/* rtl/motor_encoder_angle_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_encoder_angle_tracker: multi-turn encoder unwrap to joint angles
//
//   channel   dir   handshake               payload
//   s_axis    in    tvalid / tready          tdata 56 bits, tuser capture flag
//   m_axis    out   tvalid / tready          tdata 80 bits
//   cfg       in    cfg_we_i                 cfg_idx_i, cfg_data_i (15 bits)
//
// One frame per cycle sustained while m_axis_tready holds; a frame passes
// the queue, the per-motor unwrap stage (a single read-modify-write of the
// motor's state) and the angle pipeline stages A, B, C and output, in order.
// Reset clears all per-motor state and loads the register defaults at once.
// An output stall fills the pipeline and then the four-word queue before
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module motor_encoder_angle_tracker
  import met_pkg::*;
#(
  parameter int MOTORS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // motor_index[2:0], encoder_count[15:3],
                                      // speed_raw[31:16], current_raw[47:32],
                                      // temperature_raw[55:48]
  input  logic        s_axis_tuser,   // capture_offset
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // motor_id[2:0], joint_angle[19:3],
                                      // turn_count[35:20], output_speed[48:36],
                                      // current_out[64:49], temperature_out[72:65]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [12:0] jump_threshold_q;
  logic [14:0] fold_limit_q;

  logic        push_valid, push_ready, pop_valid, pop_ready;
  met_item_t   push_item, pop_item;
  logic        unw_valid, unw_ready;
  met_unw_t    unw;
  met_result_t res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_threshold_q <= JUMP_RESET;
      fold_limit_q     <= FOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_JUMP_THRESHOLD: jump_threshold_q <= cfg_data_i[12:0];
        CFG_FOLD_LIMIT:     fold_limit_q     <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  met_front #(
    .MOTORS (MOTORS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  met_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  met_unwrap #(
    .MOTORS (MOTORS)
  ) u_unwrap (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .jump_threshold_i (jump_threshold_q),
    .in_valid_i       (pop_valid),
    .in_ready_o       (pop_ready),
    .in_item_i        (pop_item),
    .out_valid_o      (unw_valid),
    .out_ready_i      (unw_ready),
    .out_unw_o        (unw)
  );

  met_angle u_angle (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fold_limit_i (fold_limit_q),
    .in_valid_i   (unw_valid),
    .in_ready_o   (unw_ready),
    .in_unw_i     (unw),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_res_o    (res)
  );

  // Pack the result word, low field first
  assign m_axis_tdata = {7'd0, res.temp, res.current, res.speed, res.turns,
                         res.angle, res.motor};

endmodule
